@@ src/csst_pkg.sv @@
// ----------------------------------------------------------------------------
// csst_pkg - shared definitions for the call stack self-time tracker
// event kind codes, field widths and default sizing
// ----------------------------------------------------------------------------
package csst_pkg;

  // field widths of the beats
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned DEPTH_W  = 16;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned LDEPTH_W = 6;

  // default depth of the shadow stack
  localparam int unsigned DEF_MAX_DEPTH = 64;

  // event kinds carried in tuser
  typedef enum logic [KIND_W-1:0] {
    KIND_ENTER = 2'd0,
    KIND_LEAVE = 2'd1,
    KIND_SEED  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  // operation of the shared arithmetic unit
  typedef enum logic {
    UNIT_SAT_SUB = 1'b0,
    UNIT_ADD     = 1'b1
  } unit_op_t;

endpackage

@@ src/call_stack_self_time_tracker_top.sv @@
// latency: enter takes the accept cycle plus one per frame written (min(stack length,
//   depth) up to depth); seed the accept cycle plus one per frame below its depth
// throughput: one event at a time; leave result registered 4 cycles after the input beat,
//   next beat 5 cycles after it, later while a held result waits; other beats take one
// reset: rst_n synchronous, active low; clears stack length, broken flag, sequencer and
//   output valid; the frame memories are not cleared and need no sweep
// ----------------------------------------------------------------------------
// call_stack_self_time_tracker_top - shadow call stack self-time profiler
// keeps entry times and child-time totals per frame and emits self and total
// time for each leave event
// ----------------------------------------------------------------------------
module call_stack_self_time_tracker_top #(
  parameter int unsigned MAX_DEPTH = csst_pkg::DEF_MAX_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  // input event channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,   // call_depth [15:0], timestamp [79:16]
  input  logic [1:0]   in_tuser,   // kind [1:0]
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata   // leave_depth [5:0], self_time [69:6],
                                   // total_time [133:70], zero pad [135:134]
);

  // index width into the frame stores and width of the stack length
  localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned LW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned TW = csst_pkg::TIME_W;
  localparam int unsigned DW = csst_pkg::DEPTH_W;
  localparam int unsigned OW = csst_pkg::LDEPTH_W;

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for an event beat
    S_FILL,   // writing fresh frames, one per cycle
    S_TOT,    // frame read back: total = now - entry time
    S_SELF,   // self = total - child total, parent child total read back
    S_ACC,    // parent child total += total
    S_OUT     // hand the result to the output register
  } state_t;

  // --------------------------------------------------------------------------
  // input beat fields
  // --------------------------------------------------------------------------
  csst_pkg::kind_t   in_kind;
  logic [DW-1:0]     in_depth;
  logic [TW-1:0]     in_time;

  assign in_kind  = csst_pkg::kind_t'(in_tuser);
  assign in_depth = in_tdata[DW-1:0];
  assign in_time  = in_tdata[DW+TW-1:DW];

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  state_t          state_r;
  logic [LW-1:0]   stack_len_r;   // number of live frames
  logic            broken_r;      // sticky: enter went deeper than the store
  logic [AW-1:0]   idx_r;         // fill pointer / depth of the leaving frame
  logic [AW-1:0]   end_r;         // last entry of a fill run
  logic [OW-1:0]   ldepth_r;      // low bits of the leave depth for the result
  logic [TW-1:0]   now_r;         // timestamp of the event in progress
  logic [TW-1:0]   total_r;
  logic [TW-1:0]   self_r;
  logic [TW-1:0]   kids_r;        // child total of the leaving frame
  logic [TW-1:0]   parent_r;      // child total of the parent frame

  // output register
  logic            out_valid_r;
  logic [OW-1:0]   out_ldepth_r;
  logic [TW-1:0]   out_self_r;
  logic [TW-1:0]   out_total_r;

  logic            accept;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // depth checks done on the full 16-bit event depth
  logic            depth_fits;    // call_depth < MAX_DEPTH
  logic            depth_live;    // call_depth < stack length
  logic [DW-1:0]   stack_len_ext;

  assign stack_len_ext = DW'(stack_len_r);
  assign depth_fits    = ({1'b0, in_depth} < (DW+1)'(MAX_DEPTH));
  assign depth_live    = (in_depth < stack_len_ext);

  // --------------------------------------------------------------------------
  // frame stores: one write and one registered read port each
  // --------------------------------------------------------------------------
  logic [TW-1:0]   entry_mem [MAX_DEPTH];
  logic [TW-1:0]   child_mem [MAX_DEPTH];
  logic [TW-1:0]   entry_q;
  logic [TW-1:0]   child_q;
  logic [AW-1:0]   rd_addr;
  logic            fill_we;
  logic            acc_we;
  logic [AW-1:0]   acc_addr;

  // idle: address from the event beat; total stage: the parent frame
  assign rd_addr  = (state_r == S_IDLE) ? in_depth[AW-1:0] : idx_r - AW'(1);
  assign fill_we  = (state_r == S_FILL);
  assign acc_we   = (state_r == S_ACC) && (idx_r != '0);
  assign acc_addr = idx_r - AW'(1);

  // --------------------------------------------------------------------------
  // shared 64-bit unit: saturating subtract or wrapping add
  // --------------------------------------------------------------------------
  csst_pkg::unit_op_t unit_op;
  logic [TW-1:0]      unit_a;
  logic [TW-1:0]      unit_b;
  logic [TW:0]        unit_diff;
  logic [TW-1:0]      unit_res;

  always_comb begin
    unit_op = csst_pkg::UNIT_SAT_SUB;
    unit_a  = now_r;
    unit_b  = entry_q;
    unique case (state_r)
      S_SELF: begin
        unit_a = total_r;
        unit_b = kids_r;
      end
      S_ACC: begin
        unit_op = csst_pkg::UNIT_ADD;
        unit_a  = parent_r;
        unit_b  = total_r;
      end
      default: begin
        unit_a = now_r;
        unit_b = entry_q;
      end
    endcase
  end

  assign unit_diff = {1'b0, unit_a} - {1'b0, unit_b};

  always_comb begin
    if (unit_op == csst_pkg::UNIT_ADD) begin
      unit_res = unit_a + unit_b;
    end else if (unit_diff[TW]) begin
      // borrow: floor at zero
      unit_res = '0;
    end else begin
      unit_res = unit_diff[TW-1:0];
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (fill_we) begin
      entry_mem[idx_r] <= now_r;
    end
    if (fill_we) begin
      child_mem[idx_r] <= '0;
    end else if (acc_we) begin
      child_mem[acc_addr] <= unit_res;
    end
    entry_q <= entry_mem[rd_addr];
    child_q <= child_mem[rd_addr];
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stack_len_r <= '0;
      broken_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // the output stage reloads the register itself
      if (out_valid_r && out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            now_r    <= in_time;
            ldepth_r <= OW'(in_depth);
            unique case (in_kind)
              csst_pkg::KIND_ENTER: begin
                if (!broken_r) begin
                  if (!depth_fits) begin
                    broken_r <= 1'b1;
                  end else begin
                    // start any frames never seen entered, then this one
                    idx_r       <= (stack_len_ext < in_depth) ? AW'(stack_len_r)
                                                              : in_depth[AW-1:0];
                    end_r       <= in_depth[AW-1:0];
                    stack_len_r <= LW'(in_depth + DW'(1));
                    state_r     <= S_FILL;
                  end
                end
              end
              csst_pkg::KIND_LEAVE: begin
                if (!broken_r && depth_live) begin
                  idx_r       <= in_depth[AW-1:0];
                  stack_len_r <= LW'(in_depth);
                  state_r     <= S_TOT;
                end
              end
              csst_pkg::KIND_SEED: begin
                broken_r <= 1'b0;
                if (depth_fits) begin
                  stack_len_r <= LW'(in_depth);
                  if (in_depth != '0) begin
                    idx_r   <= '0;
                    end_r   <= in_depth[AW-1:0] - AW'(1);
                    state_r <= S_FILL;
                  end
                end else begin
                  stack_len_r <= '0;
                end
              end
              csst_pkg::KIND_CLEAR: begin
                stack_len_r <= '0;
                broken_r    <= 1'b0;
              end
              default: begin
                stack_len_r <= stack_len_r;
              end
            endcase
          end
        end
        S_FILL: begin
          if (idx_r == end_r) begin
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + AW'(1);
          end
        end
        S_TOT: begin
          total_r <= unit_res;
          kids_r  <= child_q;
          state_r <= S_SELF;
        end
        S_SELF: begin
          self_r   <= unit_res;
          parent_r <= child_q;
          state_r  <= S_ACC;
        end
        S_ACC: begin
          // parent credit written by the memory block this cycle
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_ldepth_r <= ldepth_r;
            out_self_r   <= self_r;
            out_total_r  <= total_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_total_r, out_self_r, out_ldepth_r};

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - call stack self-time tracker
// streams enter, leave, seed and clear beats into the tracker with random
// idling on both channels, keeps a shadow copy of the frame store to predict
// every leave result, and checks each result beat field by field
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned STACK_DEPTH  = csst_pkg::DEF_MAX_DEPTH;
  localparam int unsigned DEPTH_W      = csst_pkg::DEPTH_W;
  localparam int unsigned TIME_W       = csst_pkg::TIME_W;
  localparam int unsigned LDEPTH_W     = csst_pkg::LDEPTH_W;
  // worst case per beat is a full fill plus a sender gap and a receiver stall,
  // taken several times over for roughly 650 beats
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // longest enter fill plus the leave pipeline, with margin
  localparam int unsigned DRAIN_CYCLES = STACK_DEPTH + 40;
  localparam int unsigned RANDOM_ITEMS = 550;
  localparam int unsigned TAIL_ITEMS   = 50;

  // one leave result as it appears on the result channel
  typedef struct {
    logic [LDEPTH_W-1:0] depth;
    logic [TIME_W-1:0]   self_ns;
    logic [TIME_W-1:0]   total_ns;
  } leave_result_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [79:0]  in_tdata   = '0;   // call_depth [15:0], timestamp [79:16]
  logic [1:0]   in_tuser   = '0;   // kind [1:0]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;         // leave_depth [5:0], self_time [69:6],
                                   // total_time [133:70], zero pad [135:134]

  // shadow copy of the tracker state
  logic [TIME_W-1:0] frame_entry [STACK_DEPTH];
  logic [TIME_W-1:0] frame_child [STACK_DEPTH];
  int unsigned       shadow_len;
  bit                shadow_broken;

  leave_result_t     expected_leaves [$];
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count    = 0;
  int unsigned       stall_left     = 0;
  bit                idling_on;
  bit                last_effective;   // last accepted beat changed state or gave a result
  logic [TIME_W-1:0] clock_ns;         // running event time of the call walk

  always #5 clk = ~clk;

  call_stack_self_time_tracker_top #(
    .MAX_DEPTH (STACK_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_leaves.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic logic [TIME_W-1:0] sat_sub(logic [TIME_W-1:0] a,
                                                logic [TIME_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  // applies one accepted event to the shadow stack, queues the leave result if
  // one is due, and returns whether the event had any effect at all
  function automatic bit track_event(csst_pkg::kind_t kind, logic [DEPTH_W-1:0] depth,
                                     logic [TIME_W-1:0] ts);
    leave_result_t res;
    int unsigned   d;
    d = 32'(depth);
    // seed and clear act even on a broken stack, and clear it
    if (kind == csst_pkg::KIND_SEED) begin
      shadow_broken = 1'b0;
      if (d < STACK_DEPTH) begin
        for (int unsigned i = 0; i < d; i++) begin
          frame_entry[i] = ts;
          frame_child[i] = '0;
        end
        shadow_len = d;
      end else begin
        shadow_len = 0;
      end
      return 1'b1;
    end
    if (kind == csst_pkg::KIND_CLEAR) begin
      shadow_len    = 0;
      shadow_broken = 1'b0;
      return 1'b1;
    end
    if (shadow_broken)
      return 1'b0;
    if (kind == csst_pkg::KIND_ENTER) begin
      // too deep for the store: sticky broken flag, nothing else moves
      if (d >= STACK_DEPTH) begin
        shadow_broken = 1'b1;
        return 1'b1;
      end
      // frames skipped over start now with no child time
      for (int unsigned i = shadow_len; i < d; i++) begin
        frame_entry[i] = ts;
        frame_child[i] = '0;
      end
      frame_entry[d] = ts;
      frame_child[d] = '0;
      shadow_len     = d + 1;
      return 1'b1;
    end
    // leave of a frame that is not live is dropped
    if (d >= shadow_len)
      return 1'b0;
    res.depth    = depth[LDEPTH_W-1:0];
    res.total_ns = sat_sub(ts, frame_entry[d]);
    res.self_ns  = sat_sub(res.total_ns, frame_child[d]);
    // credit the parent, wrapping at 64 bits; the root has no parent
    if (d > 0)
      frame_child[d-1] = frame_child[d-1] + res.total_ns;
    shadow_len = d;
    expected_leaves.push_back(res);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // driving and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // sends one event beat; tvalid stays high afterwards so that back-to-back
  // beats never lower and raise it in the same step
  task automatic send_event(csst_pkg::kind_t kind, logic [DEPTH_W-1:0] depth,
                            logic [TIME_W-1:0] ts);
    int unsigned gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {ts, depth};
    do @(posedge clk); while (!in_tready);
    last_effective = track_event(kind, depth, ts);
  endtask

  // result side back-pressure: random stall bursts while idling is on, else always ready
  always @(posedge clk) begin
    if (!idling_on) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // every accepted result beat is matched against the oldest pending leave
  always @(posedge clk) begin : result_check
    leave_result_t got;
    leave_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.depth    = out_tdata[5:0];
      got.self_ns  = out_tdata[69:6];
      got.total_ns = out_tdata[133:70];
      if (expected_leaves.size() == 0) begin
        report_mismatch($sformatf("result beat with no leave pending, depth %0d",
                                  got.depth));
      end else begin
        want = expected_leaves.pop_front();
        if (got.depth !== want.depth)
          report_mismatch($sformatf("leave_depth %0d, wanted %0d",
                                    got.depth, want.depth));
        if (got.self_ns !== want.self_ns)
          report_mismatch($sformatf("self_time %0h, wanted %0h",
                                    got.self_ns, want.self_ns));
        if (got.total_ns !== want.total_ns)
          report_mismatch($sformatf("total_time %0h, wanted %0h",
                                    got.total_ns, want.total_ns));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // plain nesting, leave of the root, then a leave with an empty stack
  task automatic test_nested_calls();
    send_event(csst_pkg::KIND_ENTER, 16'd0, 64'd100);
    send_event(csst_pkg::KIND_ENTER, 16'd1, 64'd150);
    send_event(csst_pkg::KIND_LEAVE, 16'd1, 64'd170);
    send_event(csst_pkg::KIND_LEAVE, 16'd0, 64'd300);
    send_event(csst_pkg::KIND_LEAVE, 16'd0, 64'd310);
  endtask

  // enters that skip frames, the deepest frame, a shallower enter that cuts
  // the stack, and a leave earlier than its entry time
  task automatic test_skipped_frames();
    send_event(csst_pkg::KIND_ENTER, 16'd4, 64'd1000);
    send_event(csst_pkg::KIND_LEAVE, 16'd4, 64'd1010);
    send_event(csst_pkg::KIND_LEAVE, 16'd3, 64'd1020);
    send_event(csst_pkg::KIND_ENTER, DEPTH_W'(STACK_DEPTH - 1), 64'd1100);
    send_event(csst_pkg::KIND_LEAVE, DEPTH_W'(STACK_DEPTH - 1), '1);
    send_event(csst_pkg::KIND_ENTER, 16'd2, 64'd2000);
    send_event(csst_pkg::KIND_LEAVE, 16'd5, 64'd2100);
    send_event(csst_pkg::KIND_LEAVE, 16'd2, 64'd1500);
  endtask

  // timestamps at both ends: child total wraps and self time floors at zero
  task automatic test_time_extremes();
    send_event(csst_pkg::KIND_CLEAR, 16'd0, '0);
    send_event(csst_pkg::KIND_ENTER, 16'd0, '0);
    send_event(csst_pkg::KIND_ENTER, 16'd1, '0);
    send_event(csst_pkg::KIND_LEAVE, 16'd1, '1);
    send_event(csst_pkg::KIND_ENTER, 16'd1, '0);
    send_event(csst_pkg::KIND_LEAVE, 16'd1, '1);
    send_event(csst_pkg::KIND_LEAVE, 16'd0, 64'hFFFF_FFFF_FFFF_FFFD);
  endtask

  // sticky broken flag and the ways out of it, seeds small, deepest and too deep
  task automatic test_broken_stack();
    send_event(csst_pkg::KIND_ENTER, DEPTH_W'(STACK_DEPTH), 64'd5000);
    send_event(csst_pkg::KIND_LEAVE, 16'd0, 64'd5100);
    send_event(csst_pkg::KIND_SEED, 16'd5, 64'd7000);
    send_event(csst_pkg::KIND_LEAVE, 16'd4, 64'd7100);
    send_event(csst_pkg::KIND_ENTER, '1, 64'd7200);
    send_event(csst_pkg::KIND_CLEAR, '1, '1);
    send_event(csst_pkg::KIND_SEED, '1, 64'd7300);
    send_event(csst_pkg::KIND_SEED, DEPTH_W'(STACK_DEPTH - 1), 64'd8000);
    send_event(csst_pkg::KIND_LEAVE, DEPTH_W'(STACK_DEPTH - 2), 64'd8001);
  endtask

  // ---------------------------------------------------------------------------
  // random call walk
  // ---------------------------------------------------------------------------

  // mostly well-formed push and pop traffic with rising time, mixed with
  // skipped frames, shallower enters, seeds, clears, stray leaves, too-deep
  // enters and raw noise; ignored beats do not count towards the total
  task automatic run_call_walk(int unsigned items, bit with_idling);
    int unsigned       done;
    int unsigned       steps;
    int unsigned       pick;
    int unsigned       d;
    csst_pkg::kind_t   kind;
    logic [TIME_W-1:0] ts;
    done  = 0;
    steps = 0;
    while (done < items) begin
      // alternate stretches with and without idling
      if (steps % 64 == 0)
        idling_on = with_idling && ($urandom_range(0, 3) != 0);
      steps++;
      clock_ns = clock_ns + TIME_W'($urandom_range(0, 1000));
      ts       = clock_ns;
      kind     = csst_pkg::KIND_ENTER;
      d        = shadow_len;
      pick     = $urandom_range(0, 99);
      if (!with_idling) begin
        // tail: clean nesting only, leaving a broken stack first
        if (shadow_broken) begin
          kind = csst_pkg::KIND_CLEAR;
          d    = 0;
        end else if (shadow_len > 0 && (pick < 50 || shadow_len == STACK_DEPTH)) begin
          kind = csst_pkg::KIND_LEAVE;
          d    = shadow_len - 1;
        end
      end else if (shadow_broken && pick < 60) begin
        kind = (pick < 30) ? csst_pkg::KIND_CLEAR : csst_pkg::KIND_SEED;
        d    = $urandom_range(0, STACK_DEPTH);
      end else if (pick < 38 && shadow_len < STACK_DEPTH) begin
        d = shadow_len;
      end else if (pick < 75 && shadow_len > 0) begin
        kind = csst_pkg::KIND_LEAVE;
        d    = shadow_len - 1;
      end else if (pick < 80) begin
        d = shadow_len + $urandom_range(1, 8);
        if (d > STACK_DEPTH - 1)
          d = STACK_DEPTH - 1;
      end else if (pick < 84) begin
        d = $urandom_range(0, STACK_DEPTH - 1);
      end else if (pick < 87) begin
        kind = csst_pkg::KIND_SEED;
        d    = $urandom_range(0, STACK_DEPTH);
      end else if (pick < 89) begin
        kind = csst_pkg::KIND_CLEAR;
        d    = $urandom_range(0, 65535);
      end else if (pick < 92) begin
        kind = csst_pkg::KIND_LEAVE;
        d    = $urandom_range(0, STACK_DEPTH + 2);
      end else if (pick < 94) begin
        d = $urandom_range(STACK_DEPTH, 65535);
      end else begin
        // raw noise over every bit of every field
        kind = csst_pkg::kind_t'($urandom_range(0, 3));
        d    = $urandom_range(0, 65535);
        ts   = {$urandom, $urandom};
        if (pick >= 98)
          clock_ns = ts;
      end
      send_event(kind, DEPTH_W'(d), ts);
      if (last_effective)
        done++;
    end
  endtask

  task automatic test_random_call_walk();
    run_call_walk(RANDOM_ITEMS, 1'b1);
  endtask

  // closing stretch with both channels running flat out
  task automatic test_back_to_back_tail();
    run_call_walk(TAIL_ITEMS, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    for (int unsigned i = 0; i < STACK_DEPTH; i++) begin
      frame_entry[i] = '0;
      frame_child[i] = '0;
    end
    shadow_len    = 0;
    shadow_broken = 1'b0;
    clock_ns      = '0;
    idling_on     = 1'b1;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_nested_calls();
    test_skipped_frames();
    test_time_extremes();
    test_broken_stack();
    test_random_call_walk();
    test_back_to_back_tail();

    in_tvalid <= 1'b0;
    // the watchdog covers a result that never comes
    while (expected_leaves.size() != 0) @(posedge clk);
    // room for a stray result after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_leaves.size() != 0)
      report_mismatch($sformatf("%0d leave results never arrived",
                                expected_leaves.size()));

    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ call_stack_self_time_tracker_top.f @@
src/csst_pkg.sv
src/call_stack_self_time_tracker_top.sv
dv/testbench.sv
